// ===== hdl/sme_pkg.sv =====
// Package for the stack machine executor: opcodes, status codes, datapath command type.
// Used by sme_datapath, sme_control, stack_machine_executor and sme_checker.
`default_nettype none
package sme_pkg;
   localparam logic [7:0] OP_HALT  = 8'd0;
   localparam logic [7:0] OP_PUSHC = 8'd1;
   localparam logic [7:0] OP_ADD   = 8'd2;
   localparam logic [7:0] OP_SUB   = 8'd3;
   localparam logic [7:0] OP_MUL   = 8'd4;
   localparam logic [7:0] OP_DIV   = 8'd5;
   localparam logic [7:0] OP_MOD   = 8'd6;
   localparam logic [7:0] OP_RDI   = 8'd7;
   localparam logic [7:0] OP_WRI   = 8'd8;
   localparam logic [7:0] OP_RDC   = 8'd9;
   localparam logic [7:0] OP_WRC   = 8'd10;
   localparam logic [7:0] OP_PUSHG = 8'd11;
   localparam logic [7:0] OP_POPG  = 8'd12;
   localparam logic [7:0] OP_ASF   = 8'd13;
   localparam logic [7:0] OP_RSF   = 8'd14;
   localparam logic [7:0] OP_PUSHL = 8'd15;
   localparam logic [7:0] OP_POPL  = 8'd16;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_HALT   = 3'd1;
   localparam logic [2:0] ST_DIV0   = 3'd2;
   localparam logic [2:0] ST_STACK  = 3'd3;
   localparam logic [2:0] ST_GLOBAL = 3'd4;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_INT  = 2'd1;
   localparam logic [1:0] KIND_CHAR = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic decode;   // check the item and issue the memory reads
      logic execute;  // read data valid: compute, write, update pointers
      logic div_step; // advance the divider one bit
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic stopped;
   } stat_type;
endpackage
`default_nettype wire

// ===== hdl/stack_machine_executor.sv =====
// Top level of the stack machine executor: controller plus datapath.
// Depends on sme_pkg, sme_control, sme_datapath and sme_divider.
// Each instruction is decoded with its stack reads at its transfer edge and executed in
// the next cycle; the result is registered when execution finishes and held until it is
// transferred, and only then does the block accept another instruction. Div and mod
// wait for the bit-serial divider. Reset is synchronous and clears the pointers and the
// stopped flag; stack and global memories are not cleared.
`default_nettype none
module stack_machine_executor #(
   parameter int STACK_DEPTH  = 1024,
   parameter int GLOBAL_COUNT = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instruction,
   input  wire logic [31:0] req_read_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_out_kind,
   output logic [31:0]      rsp_out_value,
   output logic [2:0]       rsp_status,
   output logic             rsp_halted
);
   import sme_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller allows one instruction in flight at a time.
   sme_control u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .stat(stat)
   );

   // The datapath holds the result steady while the transfer is stalled.
   sme_datapath #(.STACK_DEPTH(STACK_DEPTH), .GLOBAL_COUNT(GLOBAL_COUNT)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .instruction(req_instruction), .read_value(req_read_value),
      .out_kind(rsp_out_kind), .out_value(rsp_out_value), .status(rsp_status)
   );

   // The halted flag follows the stopped state, updated with the result.
   assign rsp_halted = stat.stopped;
endmodule
`default_nettype wire

// ===== hdl/sme_divider.sv =====
// Radix-2 restoring divider for signed 32-bit div and mod, truncating toward zero.
// Depends on nothing but its ports.
`default_nettype none
module sme_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        step,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient,
   output logic [31:0]      remainder
);
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] trial;
   logic [31:0] shifted;

   always_comb begin
      shifted = {r_ff[30:0], q_ff[31]};
      trial = {1'b0, shifted} - {1'b0, d_ff};
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      qneg_in = qneg_ff; rneg_in = rneg_ff;
      if (start) begin
         q_in = dividend[31] ? (32'd0 - dividend) : dividend;
         d_in = divisor[31] ? (32'd0 - divisor) : divisor;
         r_in = 32'd0;
         cnt_in = 6'd32;
         qneg_in = dividend[31] ^ divisor[31];
         rneg_in = dividend[31];
      end else if (step && cnt_ff != 6'd0) begin
         // The remainder is always below the divisor, so a 33-bit trial suffices.
         if (!trial[32] || r_ff[31]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in;
   end

   assign done = (cnt_ff == 6'd0);
   assign quotient = qneg_ff ? (32'd0 - q_ff) : q_ff;
   assign remainder = rneg_ff ? (32'd0 - r_ff) : r_ff;
endmodule
`default_nettype wire

// ===== hdl/sme_datapath.sv =====
// Datapath: operand stack memory, global store, pointers, checks and arithmetic.
// Depends on sme_pkg and sme_divider.
`default_nettype none
module sme_datapath #(
   parameter int STACK_DEPTH  = 1024,
   parameter int GLOBAL_COUNT = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sme_pkg::cmd_type  cmd,
   output sme_pkg::stat_type      stat,
   input  wire logic [31:0]       instruction,
   input  wire logic [31:0]       read_value,
   output logic [1:0]             out_kind,
   output logic [31:0]            out_value,
   output logic [2:0]             status
);
   import sme_pkg::*;
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int PW = SW + 1;
   localparam int GW = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;

   logic [31:0] stack_mem [STACK_DEPTH];
   logic [31:0] glob_mem  [GLOBAL_COUNT];

   logic [PW-1:0] top_ff, top_in, fb_ff, fb_in;
   logic          stop_ff, stop_in;
   logic [7:0]    op_ff;
   logic [31:0]   ins_ff, rv_ff;
   logic [SW-1:0] ra_addr, rb_addr;
   logic [31:0]   ra_ff, rb_ff, g_ff;
   logic [2:0]    err_ff, err_in;
   logic [SW-1:0] lidx_ff;
   logic [1:0]    kind_in;
   logic [31:0]   val_in;

   // Decode-time signals.
   logic [7:0]  op;
   logic [25:0] arg;    // sign-extended argument, wide enough for sums
   logic [25:0] top_x, fb_x, sum_t, sum_l;
   logic        full, empty, lt2, gbad, lbad;

   always_comb begin
      op = instruction[31:24];
      arg = {{2{instruction[23]}}, instruction[23:0]};
      top_x = 26'(top_ff);
      fb_x = 26'(fb_ff);
      sum_t = top_x + 26'd1 + arg;
      sum_l = fb_x + arg;
      full = (top_x >= 26'(STACK_DEPTH));
      empty = (top_ff == '0);
      lt2 = (top_x < 26'd2);
      gbad = instruction[23] || (arg >= 26'(GLOBAL_COUNT));
      lbad = sum_l[25] || (sum_l >= 26'(STACK_DEPTH));
      err_in = ST_OK;
      ra_addr = SW'(top_ff - PW'(1));
      rb_addr = SW'(top_ff - PW'(2));
      unique case (op)
         OP_HALT: err_in = ST_HALT;
         OP_PUSHC, OP_RDI, OP_RDC: if (full) err_in = ST_STACK;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: if (lt2) err_in = ST_STACK;
         OP_WRI, OP_WRC: if (empty) err_in = ST_STACK;
         OP_PUSHG: begin
            if (full) err_in = ST_STACK;
            else if (gbad) err_in = ST_GLOBAL;
         end
         OP_POPG: begin
            if (empty) err_in = ST_STACK;
            else if (gbad) err_in = ST_GLOBAL;
         end
         OP_ASF: if (full || sum_t[25] || sum_t > 26'(STACK_DEPTH)) err_in = ST_STACK;
         OP_RSF: begin
            if (fb_ff == '0 || fb_x > 26'(STACK_DEPTH)) err_in = ST_STACK;
            ra_addr = SW'(fb_ff - PW'(1));
         end
         OP_PUSHL: begin
            if (full || lbad) err_in = ST_STACK;
            ra_addr = SW'(sum_l);
         end
         OP_POPL: if (empty || lbad) err_in = ST_STACK;
         default: err_in = ST_OK;
      endcase
   end

   // Execute-time signals.
   logic [31:0] lhs, rhs, prod, q, r, wdata;
   logic        div_done, we;
   logic [SW-1:0] waddr;
   logic        err_exec;

   // The divider is started on the first execute cycle of a div or mod.
   logic div_busy_ff, div_busy_in;
   logic div_start;

   logic [2:0]  err_in_q;
   logic [1:0]  kind_ff;
   logic [31:0] val_ff;
   logic [2:0]  stat_ff;
   logic        fin;

   sme_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .step(cmd.div_step),
      .dividend(rb_ff), .divisor(ra_ff), .done(div_done),
      .quotient(q), .remainder(r)
   );

   assign lhs = rb_ff;
   assign rhs = ra_ff;
   assign prod = lhs * rhs;

   always_comb begin
      err_exec = 1'b0;
      if ((op_ff == OP_DIV || op_ff == OP_MOD) && rhs == 32'd0) err_exec = 1'b1;
      if (op_ff == OP_RSF && 33'(ra_ff) > 33'(STACK_DEPTH)) err_exec = 1'b1;
      div_start = cmd.execute && !div_busy_ff && !stop_ff && err_ff == ST_OK && !err_exec
                  && (op_ff == OP_DIV || op_ff == OP_MOD);
      div_busy_in = div_busy_ff;
      if (div_start) div_busy_in = 1'b1;
      else if (cmd.execute && div_busy_ff && div_done) div_busy_in = 1'b0;

      top_in = top_ff; fb_in = fb_ff; stop_in = stop_ff;
      kind_in = KIND_NONE; val_in = 32'd0;
      we = 1'b0; waddr = SW'(top_ff); wdata = 32'd0;
      // The final step: taken when no division is outstanding.
      if (cmd.execute && !div_start && !(div_busy_ff && !div_done)) begin
         if (stop_ff) begin
            err_in_q = ST_HALT;
         end else if (err_ff != ST_OK) begin
            err_in_q = err_ff;
            stop_in = 1'b1;
         end else if (err_exec) begin
            err_in_q = (op_ff == OP_RSF) ? ST_STACK : ST_DIV0;
            stop_in = 1'b1;
         end else begin
            err_in_q = ST_OK;
            unique case (op_ff)
               OP_PUSHC: begin
                  we = 1'b1; wdata = {{8{ins_ff[23]}}, ins_ff[23:0]};
                  top_in = top_ff + PW'(1);
               end
               OP_RDI, OP_RDC: begin
                  we = 1'b1;
                  wdata = (op_ff == OP_RDI) ? rv_ff : {{24{rv_ff[7]}}, rv_ff[7:0]};
                  top_in = top_ff + PW'(1);
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                  we = 1'b1; waddr = SW'(top_ff - PW'(2));
                  unique case (op_ff)
                     OP_ADD: wdata = lhs + rhs;
                     OP_SUB: wdata = lhs - rhs;
                     OP_MUL: wdata = prod;
                     OP_DIV: wdata = q;
                     default: wdata = r;
                  endcase
                  top_in = top_ff - PW'(1);
               end
               OP_WRI, OP_WRC: begin
                  kind_in = (op_ff == OP_WRI) ? KIND_INT : KIND_CHAR;
                  val_in = (op_ff == OP_WRI) ? ra_ff : {24'd0, ra_ff[7:0]};
                  top_in = top_ff - PW'(1);
               end
               OP_PUSHG: begin
                  we = 1'b1; wdata = g_ff; top_in = top_ff + PW'(1);
               end
               OP_POPG: top_in = top_ff - PW'(1);
               OP_ASF: begin
                  we = 1'b1; wdata = 32'(fb_ff);
                  fb_in = top_ff + PW'(1);
                  top_in = PW'(26'(top_ff) + 26'd1 + {{2{ins_ff[23]}}, ins_ff[23:0]});
               end
               OP_RSF: begin
                  top_in = fb_ff - PW'(1);
                  fb_in = PW'(ra_ff);
               end
               OP_PUSHL: begin
                  we = 1'b1; wdata = ra_ff; top_in = top_ff + PW'(1);
               end
               OP_POPL: begin
                  we = 1'b1; waddr = lidx_ff; wdata = ra_ff;
                  top_in = top_ff - PW'(1);
               end
               default: we = 1'b0;
            endcase
         end
      end else begin
         err_in_q = status;
      end
   end

   assign fin = cmd.execute && !div_start && !(div_busy_ff && !div_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0; fb_ff <= '0; stop_ff <= 1'b0; div_busy_ff <= 1'b0;
      end else begin
         top_ff <= top_in; fb_ff <= fb_in; stop_ff <= stop_in; div_busy_ff <= div_busy_in;
      end
      if (cmd.decode) begin
         op_ff <= instruction[31:24]; ins_ff <= instruction; rv_ff <= read_value;
         err_ff <= err_in; lidx_ff <= SW'(sum_l);
         ra_ff <= stack_mem[ra_addr];
         rb_ff <= stack_mem[rb_addr];
         g_ff <= glob_mem[GW'(instruction[23:0])];
      end
      if (we) stack_mem[waddr] <= wdata;
      if (fin && !stop_ff && err_ff == ST_OK && !err_exec && op_ff == OP_POPG)
         glob_mem[GW'(ins_ff[23:0])] <= ra_ff;
      if (fin) begin
         kind_ff <= kind_in; val_ff <= val_in; stat_ff <= err_in_q;
      end
   end

   assign out_kind = kind_ff;
   assign out_value = val_ff;
   assign status = stat_ff;
   assign stat = '{div_done: fin, stopped: stop_ff};
endmodule
`default_nettype wire

// ===== hdl/sme_control.sv =====
// Controller: sequences decode, execute and result hand-off for one item at a time.
// Depends on sme_pkg.
`default_nettype none
module sme_control (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sme_pkg::cmd_type       cmd,
   input  wire sme_pkg::stat_type stat
);
   import sme_pkg::*;
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_OUT);
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.decode = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = S_OUT;
         end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/sme_checker.sv =====
// Port-level checker for the stack machine executor, bound to the top level.
// Depends on sme_pkg and stack_machine_executor's ports.
`default_nettype none
module sme_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_out_kind,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_halted
);
   import sme_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result changed while stalled");
   a_fault_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_halted)
      else $error("fault without halt");
   a_kind_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != KIND_NONE |-> rsp_status == ST_OK)
      else $error("output on fault");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("accepting while result pending");
endmodule

bind stack_machine_executor sme_checker u_chk (.*);
`default_nettype wire

// ===== verif/stack_machine_executor_test.sv =====
// Self-checking testbench for the stack machine executor: a directed table, then random
// well-formed programs, then one deliberate stop. Depends on sme_pkg and the executor RTL.
`default_nettype none
module stack_machine_executor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sme_pkg::*;

   localparam int DEPTH     = 1024;
   localparam int GCOUNT    = 256;
   localparam int RAND_ITEMS = 800;

   // One result transfer as the block presents it.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [2:0]  status;
      logic        halted;
   } outcome_t;

   // One row of the directed table. Where typed is set, the outcome is written out by hand.
   typedef struct {
      logic [31:0] ins;
      logic [31:0] rv;
      bit          typed;
      outcome_t    want;
   } row_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_instruction;
   logic [31:0] req_read_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_out_kind;
   logic [31:0] rsp_out_value;
   logic [2:0]  rsp_status;
   logic        rsp_halted;

   stack_machine_executor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_instruction(req_instruction), .req_read_value(req_read_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_kind(rsp_out_kind), .rsp_out_value(rsp_out_value),
      .rsp_status(rsp_status), .rsp_halted(rsp_halted)
   );

   // The executor's architectural state as the predictor sees it. The written flags
   // let the generator steer clear of reading a stack or global word never stored.
   logic [31:0] stack_mem [0:DEPTH-1];
   bit          stack_set [0:DEPTH-1];
   logic [31:0] globals   [0:GCOUNT-1];
   bit          global_set[0:GCOUNT-1];
   int          sp;
   int          fp;
   bit          stopped;

   outcome_t    pending[$];
   int          failures;
   int          send_idle_pct;
   int          stall_pct;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Works out the outcome of one instruction. With commit clear it only looks ahead,
   // which the generator uses to reject faults and reads of unwritten words.
   function automatic void execute_insn(input logic [31:0] ins, input logic [31:0] rv,
                                        input bit commit, output outcome_t res,
                                        output bit unsafe);
      logic [7:0]  op;
      longint      arg;
      longint      a;
      longint      b;
      longint      t;
      logic [31:0] lhs;
      logic [31:0] rhs;
      logic [31:0] saved;
      logic [1:0]  kind;
      logic [31:0] value;
      logic [2:0]  status;
      op     = ins[31:24];
      arg    = longint'($signed(ins[23:0]));
      kind   = KIND_NONE;
      value  = '0;
      status = ST_OK;
      unsafe = 1'b0;
      if (stopped) begin
         res = '{KIND_NONE, 32'd0, ST_HALT, 1'b1};
         return;
      end
      case (op)
         OP_HALT: begin
            status = ST_HALT;
         end
         OP_PUSHC: begin
            if (sp >= DEPTH) status = ST_STACK;
            else if (commit) begin
               stack_mem[sp] = ins[23] ? {8'hFF, ins[23:0]} : {8'h00, ins[23:0]};
               stack_set[sp] = 1'b1;
               sp++;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
            if (sp < 2) status = ST_STACK;
            else begin
               unsafe = !stack_set[sp-1] || !stack_set[sp-2];
               rhs = stack_mem[sp-1];
               lhs = stack_mem[sp-2];
               a = longint'($signed(lhs));
               b = longint'($signed(rhs));
               if ((op == OP_DIV || op == OP_MOD) && rhs == 0) status = ST_DIV0;
               else if (commit) begin
                  case (op)
                     OP_ADD:  stack_mem[sp-2] = lhs + rhs;
                     OP_SUB:  stack_mem[sp-2] = lhs - rhs;
                     OP_MUL:  stack_mem[sp-2] = lhs * rhs;
                     // Truncating division; the most negative value over minus one wraps.
                     OP_DIV:  stack_mem[sp-2] = 32'(a / b);
                     default: stack_mem[sp-2] = 32'(a % b);
                  endcase
                  sp--;
               end
            end
         end
         OP_RDI, OP_RDC: begin
            if (sp >= DEPTH) status = ST_STACK;
            else if (commit) begin
               stack_mem[sp] = (op == OP_RDI) ? rv : {{24{rv[7]}}, rv[7:0]};
               stack_set[sp] = 1'b1;
               sp++;
            end
         end
         OP_WRI, OP_WRC: begin
            if (sp == 0) status = ST_STACK;
            else begin
               unsafe = !stack_set[sp-1];
               value  = stack_mem[sp-1];
               if (op == OP_WRI) kind = KIND_INT;
               else begin
                  kind  = KIND_CHAR;
                  value = {24'd0, value[7:0]};
               end
               if (commit) sp--;
            end
         end
         OP_PUSHG: begin
            if (sp >= DEPTH) status = ST_STACK;
            else if (arg < 0 || arg >= GCOUNT) status = ST_GLOBAL;
            else begin
               unsafe = !global_set[arg];
               if (commit) begin
                  stack_mem[sp] = globals[arg];
                  stack_set[sp] = 1'b1;
                  sp++;
               end
            end
         end
         OP_POPG: begin
            if (sp == 0) status = ST_STACK;
            else if (arg < 0 || arg >= GCOUNT) status = ST_GLOBAL;
            else begin
               unsafe = !stack_set[sp-1];
               if (commit) begin
                  globals[arg]    = stack_mem[sp-1];
                  global_set[arg] = 1'b1;
                  sp--;
               end
            end
         end
         OP_ASF: begin
            t = longint'(sp) + 1 + arg;
            if (sp >= DEPTH || t < 0 || t > DEPTH) status = ST_STACK;
            else if (commit) begin
               stack_mem[sp] = 32'(fp);
               stack_set[sp] = 1'b1;
               fp = sp + 1;
               sp = int'(t);
            end
         end
         OP_RSF: begin
            if (fp == 0 || fp > DEPTH) status = ST_STACK;
            else begin
               unsafe = !stack_set[fp-1];
               saved  = stack_mem[fp-1];
               if (saved > DEPTH) status = ST_STACK;
               else if (commit) begin
                  sp = fp - 1;
                  fp = int'(saved);
               end
            end
         end
         OP_PUSHL: begin
            t = longint'(fp) + arg;
            if (sp >= DEPTH || t < 0 || t >= DEPTH) status = ST_STACK;
            else begin
               unsafe = !stack_set[t];
               if (commit) begin
                  stack_mem[sp] = stack_mem[t];
                  stack_set[sp] = 1'b1;
                  sp++;
               end
            end
         end
         OP_POPL: begin
            t = longint'(fp) + arg;
            if (sp == 0 || t < 0 || t >= DEPTH) status = ST_STACK;
            else begin
               unsafe = !stack_set[sp-1];
               if (commit) begin
                  sp--;
                  stack_mem[t] = stack_mem[sp];
                  stack_set[t] = 1'b1;
               end
            end
         end
         default: ;
      endcase
      if (status != ST_OK) begin
         kind  = KIND_NONE;
         value = '0;
         if (commit) stopped = 1'b1;
      end
      res = '{kind, value, status, (status != ST_OK) || stopped};
   endfunction

   // Draws a random instruction that the block can run without stopping.
   function automatic logic [31:0] draw_insn();
      logic [31:0] ins;
      logic [7:0]  op;
      logic [23:0] arg;
      outcome_t    res;
      bit          unsafe;
      int          tries;
      for (tries = 0; tries < 200; tries++) begin
         op  = 8'($urandom_range(OP_PUSHC, OP_POPL));
         arg = 24'($urandom());
         case (op)
            OP_PUSHG, OP_POPG: arg = 24'($urandom_range(0, GCOUNT - 1));
            OP_ASF:            arg = 24'(int'($urandom_range(0, 5)) - 1);
            OP_PUSHL, OP_POPL: if (sp > 0) arg = 24'(int'($urandom_range(0, sp - 1)) - fp);
            default: ;
         endcase
         ins = {op, arg};
         if ($urandom_range(99) < 6) ins = {8'($urandom_range(OP_POPL + 1, 255)), arg};
         if ($urandom_range(99) < 4) ins = $urandom();
         execute_insn(ins, 32'd0, 1'b0, res, unsafe);
         if (!unsafe && res.status == ST_OK) return ins;
      end
      // An unknown opcode always runs harmlessly.
      return {8'hFF, 24'($urandom())};
   endfunction

   // Presents one instruction and holds it until the block takes it; the expectation is
   // recorded at the transfer edge.
   task automatic issue(input logic [31:0] ins, input logic [31:0] rv, input bit typed,
                        input outcome_t want);
      outcome_t res;
      bit       unsafe;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_instruction <= ins;
      req_read_value  <= rv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      execute_insn(ins, rv, 1'b1, res, unsafe);
      pending.push_back(typed ? want : res);
   endtask

   // Receiver side: stall at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Each result transfer is compared field by field with the oldest expectation.
   always @(posedge clock) begin
      outcome_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending.size() == 0) begin
            $error("result transfer with nothing expected");
            failures++;
         end else begin
            want = pending.pop_front();
            if (rsp_out_kind !== want.kind) begin
               $error("out_kind: expected %0d, got %0d", want.kind, rsp_out_kind);
               failures++;
            end
            if (rsp_out_value !== want.value) begin
               $error("out_value: expected %h, got %h", want.value, rsp_out_value);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_halted !== want.halted) begin
               $error("halted: expected %0d, got %0d", want.halted, rsp_halted);
               failures++;
            end
         end
      end
   end

   // A fixed ceiling far above the slowest legal run.
   initial begin
      #6000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      row_t     rows[$];
      outcome_t none_ok;
      outcome_t after_stop;
      int       i;
      int       pick;
      int       waited;
      none_ok    = '{KIND_NONE, 32'd0, ST_OK, 1'b0};
      after_stop = '{KIND_NONE, 32'd0, ST_HALT, 1'b1};
      failures        = 0;
      sp              = 0;
      fp              = 0;
      stopped         = 1'b0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_instruction = '0;
      req_read_value  = '0;
      rsp_stall       = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table: argument extremes, wrapping division, character sign extension,
      // both ends of the global store, a frame with locals, and an unknown opcode.
      rows = '{
         '{{OP_PUSHC, 24'h7FFFFF}, 32'd0, 1'b1, none_ok},
         '{{OP_PUSHC, 24'h800000}, 32'd0, 1'b0, none_ok},
         '{{OP_ADD, 24'd0},        32'd0, 1'b0, none_ok},
         '{{OP_RDI, 24'd0},        32'h8000_0000, 1'b0, none_ok},
         '{{OP_RDI, 24'd0},        32'hFFFF_FFFF, 1'b0, none_ok},
         '{{OP_DIV, 24'd0},        32'd0, 1'b0, none_ok},
         '{{OP_RDI, 24'd0},        32'h8000_0000, 1'b0, none_ok},
         '{{OP_RDI, 24'd0},        32'hFFFF_FFFF, 1'b0, none_ok},
         '{{OP_MOD, 24'd0},        32'd0, 1'b0, none_ok},
         '{{OP_RDC, 24'd0},        32'h1234_5680, 1'b0, none_ok},
         '{{OP_WRC, 24'd0},        32'd0, 1'b1, '{KIND_CHAR, 32'h80, ST_OK, 1'b0}},
         '{{OP_WRI, 24'd0},        32'd0, 1'b1, '{KIND_INT, 32'd0, ST_OK, 1'b0}},
         '{{OP_PUSHC, 24'd5},      32'd0, 1'b0, none_ok},
         '{{OP_POPG, 24'd0},       32'd0, 1'b0, none_ok},
         '{{OP_PUSHG, 24'd0},      32'd0, 1'b0, none_ok},
         '{{OP_POPG, 24'd255},     32'd0, 1'b0, none_ok},
         '{{OP_PUSHG, 24'd255},    32'd0, 1'b0, none_ok},
         '{{OP_MUL, 24'd0},        32'd0, 1'b0, none_ok},
         '{{OP_SUB, 24'd0},        32'd0, 1'b0, none_ok},
         '{{OP_ASF, 24'd2},        32'd0, 1'b0, none_ok},
         '{{OP_PUSHL, 24'hFFFFFF}, 32'd0, 1'b0, none_ok},
         '{{OP_POPL, 24'd0},       32'd0, 1'b0, none_ok},
         '{{OP_PUSHL, 24'd0},      32'd0, 1'b0, none_ok},
         '{{OP_RSF, 24'd0},        32'd0, 1'b0, none_ok},
         '{32'hFF00_0000,          32'd0, 1'b1, none_ok},
         '{{OP_WRI, 24'd0},        32'd0, 1'b0, none_ok}
      };
      foreach (rows[r]) issue(rows[r].ins, rows[r].rv, rows[r].typed, rows[r].want);

      // Random programs in four pacing phases: free running, sender gaps, receiver
      // stalls, then light gaps on both sides.
      for (i = 0; i < RAND_ITEMS; i++) begin
         case ((i / 50) % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 58; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 58; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
         endcase
         issue(draw_insn(), $urandom(), 1'b0, none_ok);
      end

      // Only one stop fits in a run, so the seed chooses which one.
      pick = $urandom_range(0, 3);
      case (pick)
         0: issue({OP_HALT, 24'($urandom())}, $urandom(), 1'b1,
                  '{KIND_NONE, 32'd0, ST_HALT, 1'b1});
         1: begin
            issue({OP_PUSHC, 24'd1}, 32'd0, 1'b0, none_ok);
            issue({OP_PUSHC, 24'd0}, 32'd0, 1'b0, none_ok);
            issue({($urandom_range(1) ? OP_DIV : OP_MOD), 24'd0}, 32'd0, 1'b0, none_ok);
         end
         2: begin
            issue({OP_PUSHC, 24'd7}, 32'd0, 1'b0, none_ok);
            issue({OP_POPG, 24'($urandom_range(GCOUNT, 70000))}, 32'd0, 1'b0, none_ok);
         end
         default: issue({OP_PUSHL, 24'(-(fp + 1))}, 32'd0, 1'b0, none_ok);
      endcase
      for (i = 0; i < 6; i++) issue($urandom(), $urandom(), 1'b1, after_stop);

      @(posedge clock);
      req_valid <= 1'b0;
      stall_pct = 0;
      waited = 0;
      while (pending.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (60) @(posedge clock);
      if (failures == 0 && pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/sme_pkg.sv
hdl/sme_divider.sv
hdl/sme_datapath.sv
hdl/sme_control.sv
hdl/stack_machine_executor.sv
hdl/sme_checker.sv
verif/stack_machine_executor_test.sv
